// ----- rtl/core/bcag_pkg.sv -----
// ----------------------------------------------------------------------------
// bcag_pkg
// Types and constants shared by the clipped bitmap address generator.
// ----------------------------------------------------------------------------
package bcag_pkg;

  // Default screen size in pixels.
  localparam int DEF_SCREEN_COLUMNS = 128;
  localparam int DEF_SCREEN_ROWS    = 160;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_IDLE   = 2'd0,
    STATUS_ACCEPT = 2'd1,
    STATUS_REJECT = 2'd2,
    STATUS_PIXEL  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [14:0]        img_width;
    logic [14:0]        img_height;
    logic [31:0]        image_base;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [6:0]  col_first;
    logic [6:0]  col_final;
    logic [7:0]  row_first;
    logic [7:0]  row_final;
    logic [31:0] pixel_address;
    logic        last_pixel;
  } rsp_t;

endpackage

// ----- rtl/core/bitmap_clip_address_generator_top.sv -----
// ----------------------------------------------------------------------------
// bitmap_clip_address_generator_top
// Clips a bitmap against the screen and walks the visible source pixels.
// ----------------------------------------------------------------------------
// Usage: the command channel (cmd_valid, cmd_ready, cmd) carries one item per
// transfer. A start item gives the bitmap's bottom-left corner, size and base
// address; the block answers with the clipped window (status accept) or with
// status reject when the image is empty, larger than the screen or fully off
// screen. Each next item answers with the byte address of one visible source
// pixel, top visible row first and left to right, with last_pixel set on the
// final one; a next item with no draw in progress answers with status idle.
// A start during a draw abandons that draw.
// Every command produces exactly one response on (rsp_valid, rsp_ready, rsp).
// The response is in the output register on the cycle after the command
// transfer. Throughput is one item per cycle while responses are taken; the
// clipping math (one 8 by 9 bit multiply and a few adds) and the pixel
// stepping both sit between the command port and the response register.
// When the receiver stalls, the response is held and cmd_ready drops until
// it is taken; a command is accepted in the same cycle that the response
// register drains. Synchronous reset empties the response register and ends
// any draw.
module bitmap_clip_address_generator_top #(
  parameter int SCREEN_COLUMNS = bcag_pkg::DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = bcag_pkg::DEF_SCREEN_ROWS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  bcag_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bcag_pkg::rsp_t rsp
);
  import bcag_pkg::*;

  localparam logic signed [17:0] SCR_COLS = 18'(SCREEN_COLUMNS);
  localparam logic signed [17:0] SCR_ROWS = 18'(SCREEN_ROWS);

  // Draw state.
  logic        active;
  logic [15:0] source_index;
  logic [7:0]  column_count;
  logic [7:0]  rows_left;
  logic [7:0]  visible_width;
  logic [7:0]  skip_columns;
  logic [7:0]  stored_width;
  logic [31:0] stored_base;

  logic        active_next;
  logic [15:0] source_index_next;
  logic [7:0]  column_count_next;
  logic [7:0]  rows_left_next;
  logic [7:0]  visible_width_next;
  logic [7:0]  skip_columns_next;
  logic [7:0]  stored_width_next;
  logic [31:0] stored_base_next;
  rsp_t        rsp_next;

  logic        cmd_fire;

  // Start path.
  logic signed [17:0] x_s, y_s, w_s, h_s, top_s;
  logic signed [17:0] vw_s, vh_s, skip_s, left_s, bottom_s, top_c, col_end_s;
  logic               reject;
  logic [7:0]         mul_a;
  logic [8:0]         mul_b;
  logic [16:0]        prod;
  logic [17:0]        neg_x;
  logic [15:0]        start_index;

  // Next path.
  logic [7:0]  col_inc;
  logic [15:0] index_inc;
  logic        row_end;
  logic        last;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;

  always_comb begin
    x_s   = {{2{cmd.x_pos[15]}}, cmd.x_pos};
    y_s   = {{2{cmd.y_pos[15]}}, cmd.y_pos};
    w_s   = {3'b000, cmd.img_width};
    h_s   = {3'b000, cmd.img_height};
    top_s = y_s - h_s + 18'sd1;

    reject = (w_s == 18'sd0) || (h_s == 18'sd0) || (w_s > SCR_COLS) ||
             (h_s > SCR_ROWS) || (x_s >= SCR_COLS) || (top_s >= SCR_ROWS) ||
             ((x_s + w_s) <= 18'sd0) || (y_s < 18'sd0);

    vw_s     = w_s;
    vh_s     = h_s;
    skip_s   = 18'sd0;
    left_s   = x_s;
    bottom_s = y_s;
    top_c    = top_s;
    if (x_s + w_s - 18'sd1 >= SCR_COLS) begin
      skip_s = x_s + w_s - SCR_COLS;
      vw_s   = SCR_COLS - x_s;
    end
    if (top_s < 18'sd0) begin
      vh_s  = y_s + 18'sd1;
      top_c = 18'sd0;
    end
    if (x_s < 18'sd0) begin
      vw_s   = w_s + x_s;
      skip_s = -x_s;
      left_s = 18'sd0;
    end
    if (y_s >= SCR_ROWS) begin
      vh_s     = vh_s - (y_s - SCR_ROWS + 18'sd1);
      bottom_s = SCR_ROWS - 18'sd1;
    end
    col_end_s = left_s + vw_s - 18'sd1;

    // With the top clipped, the first emitted row starts at w * y, which is
    // the full-image start w * (h - 1) less the skipped top rows.
    mul_a = cmd.img_width[7:0];
    if (top_s < 18'sd0) begin
      mul_b = y_s[8:0];
    end else begin
      mul_b = h_s[8:0] - 9'd1;
    end
    prod  = 17'(mul_a) * 17'(mul_b);
    neg_x = -x_s;
    start_index = prod[15:0];
    if (x_s < 18'sd0) begin
      start_index = prod[15:0] + neg_x[15:0];
    end
  end

  always_comb begin
    col_inc   = column_count + 8'd1;
    index_inc = source_index + 16'd1;
    row_end   = (col_inc == visible_width);
    last      = row_end && (rows_left <= 8'd1);

    active_next        = active;
    source_index_next  = source_index;
    column_count_next  = column_count;
    rows_left_next     = rows_left;
    visible_width_next = visible_width;
    skip_columns_next  = skip_columns;
    stored_width_next  = stored_width;
    stored_base_next   = stored_base;
    rsp_next           = '0;

    case (cmd.operation)
      OP_START: begin
        if (reject) begin
          active_next     = 1'b0;
          rsp_next.status = STATUS_REJECT;
        end else begin
          active_next        = 1'b1;
          source_index_next  = start_index;
          column_count_next  = 8'd0;
          rows_left_next     = vh_s[7:0];
          visible_width_next = vw_s[7:0];
          skip_columns_next  = skip_s[7:0];
          stored_width_next  = cmd.img_width[7:0];
          stored_base_next   = cmd.image_base;
          rsp_next.status    = STATUS_ACCEPT;
          rsp_next.col_first = left_s[6:0];
          rsp_next.col_final = col_end_s[6:0];
          rsp_next.row_first = top_c[7:0];
          rsp_next.row_final = bottom_s[7:0];
        end
      end
      default: begin
        if (active) begin
          rsp_next.status        = STATUS_PIXEL;
          rsp_next.pixel_address = stored_base + {15'd0, source_index, 1'b0};
          rsp_next.last_pixel    = last;
          source_index_next      = index_inc;
          column_count_next      = col_inc;
          if (row_end) begin
            // Step back to the start of the source row below.
            column_count_next = 8'd0;
            source_index_next = index_inc + {8'd0, skip_columns} -
                                {7'd0, stored_width, 1'b0};
            rows_left_next    = rows_left - 8'd1;
            if (rows_left_next == 8'd0) begin
              active_next = 1'b0;
            end
          end
        end else begin
          rsp_next.status = STATUS_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      rsp_valid     <= 1'b0;
      source_index  <= '0;
      column_count  <= '0;
      rows_left     <= '0;
      visible_width <= '0;
      skip_columns  <= '0;
      stored_width  <= '0;
      stored_base   <= '0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd_fire) begin
        active        <= active_next;
        source_index  <= source_index_next;
        column_count  <= column_count_next;
        rows_left     <= rows_left_next;
        visible_width <= visible_width_next;
        skip_columns  <= skip_columns_next;
        stored_width  <= stored_width_next;
        stored_base   <= stored_base_next;
        rsp_valid     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      rsp <= rsp_next;
    end
  end

  a_cmd_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> rsp_valid)
    else $error("command transfer did not load a response");

  a_last_only_on_pixel: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last_pixel |-> rsp.status == STATUS_PIXEL)
    else $error("last pixel flag on a non-pixel response");

  a_start_sets_active: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.operation == OP_START |=> active == (rsp.status == STATUS_ACCEPT))
    else $error("draw state disagrees with start response");

  a_last_ends_draw: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last_pixel |-> !active)
    else $error("draw still active after last pixel");

  a_idle_when_inactive: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.operation == OP_NEXT && !active |=> rsp.status == STATUS_IDLE)
    else $error("pixel produced with no draw in progress");

endmodule
